[hw/rtl/oplp_pkg.sv]
`default_nettype none

package oplp_pkg;

  localparam int COEFF_DEPTH = 1024;
  localparam int COEFF_AW    = $clog2(COEFF_DEPTH);
  localparam int FINE_BITS   = 28 - COEFF_AW;
  localparam int L_W         = FINE_BITS + 7;
  localparam int L2_W        = (2 * L_W > 32) ? 2 * L_W - 31 : 1;
  localparam int L3_W        = (L2_W + L_W > 32) ? L2_W + L_W - 31 : 1;
  localparam int L4_W        = (L3_W + L_W > 32) ? L3_W + L_W - 31 : 1;

  localparam int DIV_W  = 50;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  localparam logic [DIV_W-1:0] EXP_NUM = DIV_W'(1000) << 40;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [24:0] ONE_Q24 = 25'h100_0000;
  localparam logic [31:0] RECIP_6  = 32'd715827883;
  localparam logic [31:0] RECIP_24 = 32'd178956971;

  localparam logic [17:0] FS_RESET = 18'd44100;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_TARGET = 2'd2;

  localparam logic REG_FS    = 1'b0;
  localparam logic REG_TICKS = 1'b1;

  localparam logic [31:0] EXP_POW2 [28] = '{
    32'd2147483520, 32'd2147483392, 32'd2147483136, 32'd2147482624, 32'd2147481600,
    32'd2147479552, 32'd2147475456, 32'd2147467264, 32'd2147450880, 32'd2147418113,
    32'd2147352580, 32'd2147221520, 32'd2146959424, 32'd2146435328, 32'd2145387520,
    32'd2143293437, 32'd2139111403, 32'd2130771798, 32'd2114190000, 32'd2081412522,
    32'd2017374191, 32'd1895147668, 32'd1672461947, 32'd1302514674, 32'd790015084,
    32'd290630308,  32'd39332535,   32'd720401
  };

  typedef logic [31:0] coarse_rom_t [COEFF_DEPTH];

  function automatic coarse_rom_t build_coarse_rom();
    coarse_rom_t rom;
    logic [63:0] r;
    logic [27:0] x;
    for (int k = 0; k < COEFF_DEPTH; k++) begin
      x = 28'(k) << FINE_BITS;
      r = 64'(ONE_Q31);
      for (int j = 0; j < 28; j++) begin
        if (x[j]) begin
          r = (r * 64'(EXP_POW2[j]) + (64'd1 << 30)) >> 31;
        end
      end
      rom[k] = r[31:0];
    end
    return rom;
  endfunction

  localparam coarse_rom_t COARSE_ROM = build_coarse_rom();

  typedef enum logic [4:0] {
    OP_NONE,
    OP_MUL_XC0,
    OP_MUL_YC1,
    OP_Y,
    OP_OUT,
    OP_TICK,
    OP_TARGET,
    OP_STEP,
    OP_MUL_DEN,
    OP_DIV_A,
    OP_COEF_ZERO,
    OP_SPLIT,
    OP_L2,
    OP_L3,
    OP_L4,
    OP_FRAC,
    OP_POLY,
    OP_MUL_TP,
    OP_COEF
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic tau_same;
    logic ramp_active;
    logic den_zero;
    logic a_big;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/oplp_div.sv]
`default_nettype none

module oplp_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [oplp_pkg::DIV_W-1:0]   num,
  input  wire  [oplp_pkg::DIV_W-1:0]   den,
  output logic                         busy,
  output logic [oplp_pkg::DIV_W-1:0]   quot
);

  logic [oplp_pkg::DIV_CW-1:0] cnt;
  logic [oplp_pkg::DIV_W-1:0]  rem;
  logic [oplp_pkg::DIV_W-1:0]  dv;
  logic [oplp_pkg::DIV_W:0]    rem_sh;
  logic                        fits;

  assign rem_sh = {rem, quot[oplp_pkg::DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == oplp_pkg::DIV_CW'(oplp_pkg::DIV_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dv   <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= oplp_pkg::DIV_W'(rem_sh - {1'b0, dv});
      end else begin
        rem <= rem_sh[oplp_pkg::DIV_W-1:0];
      end
      quot <= {quot[oplp_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/oplp_dp.sv]
`default_nettype none

module oplp_dp (
  input  wire                    clk,
  input  wire                    rst,
  input  oplp_pkg::cmd_t         cmd,
  output oplp_pkg::status_t      status,
  input  wire  [55:0]            s_tdata,
  input  wire                    cfg_we,
  input  wire                    cfg_index,
  input  wire  [17:0]            cfg_data,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [23:0]            m_tdata
);

  logic [17:0]        fs;
  logic [15:0]        ticks;
  logic signed [31:0] y_prev;
  logic [23:0]        feedback_coeff;
  logic [24:0]        input_coeff;
  logic [31:0]        cur_tau;
  logic [23:0]        final_tau;
  logic signed [31:0] tau_step;
  logic [15:0]        ramp_rem;

  logic signed [23:0] x_in;
  logic signed [24:0] tgt_in;
  logic signed [65:0] prod;
  logic signed [57:0] acc_xc0;
  logic [oplp_pkg::L_W-1:0]  l;
  logic [oplp_pkg::L2_W-1:0] l2;
  logic [oplp_pkg::L3_W-1:0] l3;
  logic [oplp_pkg::L3_W-1:0] q6;
  logic [oplp_pkg::L4_W-1:0] q24;
  logic [31:0]        t_val;
  logic [31:0]        poly;
  logic               diff_neg;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic               mul_en;

  logic               div_start;
  logic [oplp_pkg::DIV_W-1:0] div_num;
  logic [oplp_pkg::DIV_W-1:0] div_den;
  logic [oplp_pkg::DIV_W-1:0] quot;
  logic               div_busy;

  logic [15:0]        ticks_eff;
  logic [23:0]        t_cl;
  logic [31:0]        target;
  logic signed [33:0] diff;
  logic [32:0]        diff_mag;

  logic signed [57:0] acc_sum;
  logic signed [57:0] acc_rnd;
  logic signed [33:0] y_wide;
  logic signed [31:0] y_sat;
  logic signed [32:0] o_rnd;
  logic signed [24:0] o_wide;
  logic [23:0]        o_sat;

  logic signed [33:0] tau_sum;
  logic [31:0]        tau_next;
  logic [32:0]        step_q;
  logic [31:0]        step_next;

  logic [63:0]        v_full;
  logic [32:0]        v1;
  logic [25:0]        v2;
  logic [23:0]        c1_next;

  logic [32:0]        poly_sum;
  logic [63:0]        q6_prod;
  logic [63:0]        q24_prod;

  assign ticks_eff = (ticks == 16'd0) ? 16'd1 : ticks;
  assign t_cl      = tgt_in[24] ? 24'd0 : tgt_in[23:0];
  assign target    = {t_cl, 8'd0};
  assign diff      = $signed({2'b00, target}) - $signed({2'b00, cur_tau});
  assign diff_mag  = diff[33] ? 33'(-diff) : diff[32:0];

  assign div_start = (cmd.op == oplp_pkg::OP_TARGET) || (cmd.op == oplp_pkg::OP_DIV_A);
  assign div_num   = (cmd.op == oplp_pkg::OP_TARGET) ? oplp_pkg::DIV_W'(diff_mag)
                                                      : oplp_pkg::EXP_NUM;
  assign div_den   = (cmd.op == oplp_pkg::OP_TARGET) ? oplp_pkg::DIV_W'(ticks_eff)
                                                      : prod[oplp_pkg::DIV_W-1:0];

  oplp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign status.tau_same    = (target == cur_tau);
  assign status.ramp_active = (ramp_rem != 16'd0);
  assign status.den_zero    = (prod[oplp_pkg::DIV_W-1:0] == '0);
  assign status.a_big       = |quot[oplp_pkg::DIV_W-1:28];
  assign status.div_busy    = div_busy;
  assign status.out_free    = !m_tvalid || m_tready;

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      oplp_pkg::OP_MUL_XC0: begin
        mul_a = 33'(x_in);
        mul_b = $signed(33'(input_coeff));
      end
      oplp_pkg::OP_MUL_YC1: begin
        mul_a = 33'(y_prev);
        mul_b = $signed(33'(feedback_coeff));
      end
      oplp_pkg::OP_MUL_DEN: begin
        mul_a = $signed(33'(fs));
        mul_b = $signed(33'(cur_tau));
      end
      oplp_pkg::OP_L2: begin
        mul_a = $signed(33'(l));
        mul_b = $signed(33'(l));
      end
      oplp_pkg::OP_L3: begin
        mul_a = $signed(33'(prod[oplp_pkg::L2_W+30:31]));
        mul_b = $signed(33'(l));
      end
      oplp_pkg::OP_L4: begin
        mul_a = $signed(33'(prod[oplp_pkg::L3_W+30:31]));
        mul_b = $signed(33'(l));
      end
      oplp_pkg::OP_MUL_TP: begin
        mul_a = $signed(33'(t_val));
        mul_b = $signed(33'(poly));
      end
      default: mul_en = 1'b0;
    endcase
  end

  // sample arithmetic
  assign acc_sum = acc_xc0 + prod[57:0];
  assign acc_rnd = acc_sum + 58'sd8388608;
  assign y_wide  = acc_rnd[57:24];
  assign y_sat   = (y_wide[33:31] == 3'b000 || y_wide[33:31] == 3'b111) ? y_wide[31:0]
                 : (y_wide[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);
  assign o_rnd   = 33'(y_prev) + 33'sd128;
  assign o_wide  = o_rnd[32:8];
  assign o_sat   = (o_wide[24] == o_wide[23]) ? o_wide[23:0]
                 : (o_wide[24] ? 24'h80_0000 : 24'h7f_ffff);

  // ramp arithmetic
  assign tau_sum  = $signed({2'b00, cur_tau}) + 34'(tau_step);
  assign tau_next = tau_sum[33] ? 32'd0
                  : (tau_sum[32] ? 32'hffff_ffff : tau_sum[31:0]);
  assign step_q   = quot[32:0];
  assign step_next = diff_neg
                   ? ((step_q > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-step_q))
                   : ((step_q > 33'h0_7fff_ffff) ? 32'h7fff_ffff : step_q[31:0]);

  // coefficient arithmetic
  assign q6_prod  = 64'(l3) * 64'(oplp_pkg::RECIP_6);
  assign q24_prod = 64'(prod[oplp_pkg::L4_W+30:31]) * 64'(oplp_pkg::RECIP_24);
  assign poly_sum = 33'(oplp_pkg::ONE_Q31) - 33'(l) + 33'(l2 >> 1) - 33'(q6) + 33'(q24);
  assign v_full   = 64'(prod[62:0]) + (64'd1 << 30);
  assign v1       = v_full[63:31];
  assign v2       = 26'((34'(v1) + 34'd64) >> 7);
  assign c1_next  = (v2 > 26'(oplp_pkg::ONE_Q24 - 25'd1)) ? 24'hff_ffff : v2[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fs             <= oplp_pkg::FS_RESET;
      ticks          <= 16'd1;
      y_prev         <= '0;
      feedback_coeff <= '0;
      input_coeff    <= oplp_pkg::ONE_Q24;
      cur_tau        <= '0;
      final_tau      <= '0;
      tau_step       <= '0;
      ramp_rem       <= 16'd1;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          oplp_pkg::REG_FS:    fs <= cfg_data;
          oplp_pkg::REG_TICKS: ticks <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tready && cmd.op != oplp_pkg::OP_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (cmd.op)
        oplp_pkg::OP_Y:   y_prev <= y_sat;
        oplp_pkg::OP_OUT: m_tvalid <= 1'b1;
        oplp_pkg::OP_TICK: begin
          if (ramp_rem <= 16'd1) begin
            cur_tau  <= {final_tau, 8'd0};
            ramp_rem <= '0;
          end else begin
            cur_tau  <= tau_next;
            ramp_rem <= ramp_rem - 16'd1;
          end
        end
        oplp_pkg::OP_TARGET: begin
          final_tau <= t_cl;
          ramp_rem  <= ticks_eff;
        end
        oplp_pkg::OP_STEP: tau_step <= step_next;
        oplp_pkg::OP_COEF_ZERO: begin
          feedback_coeff <= '0;
          input_coeff    <= oplp_pkg::ONE_Q24;
        end
        oplp_pkg::OP_COEF: begin
          feedback_coeff <= c1_next;
          input_coeff    <= oplp_pkg::ONE_Q24 - 25'(c1_next);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_in   <= s_tdata[23:0];
      tgt_in <= s_tdata[48:24];
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.op)
      oplp_pkg::OP_MUL_YC1: acc_xc0 <= {prod[49:0], 8'd0};
      oplp_pkg::OP_OUT:     m_tdata <= o_sat;
      oplp_pkg::OP_TARGET:  diff_neg <= diff[33];
      oplp_pkg::OP_SPLIT: begin
        t_val <= oplp_pkg::COARSE_ROM[quot[27:oplp_pkg::FINE_BITS]];
        l     <= {quot[oplp_pkg::FINE_BITS-1:0], 7'd0};
      end
      oplp_pkg::OP_L3: l2 <= prod[oplp_pkg::L2_W+30:31];
      oplp_pkg::OP_L4: l3 <= prod[oplp_pkg::L3_W+30:31];
      oplp_pkg::OP_FRAC: begin
        q6  <= q6_prod[oplp_pkg::L3_W+31:32];
        q24 <= q24_prod[oplp_pkg::L4_W+31:32];
      end
      oplp_pkg::OP_POLY: poly <= poly_sum[31:0];
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    26'(input_coeff) + 26'(feedback_coeff) == 26'(oplp_pkg::ONE_Q24))
    else $error("coefficients do not sum to one");

  assert property (@(posedge clk) disable iff (rst)
    ramp_rem == 16'd0 |-> cur_tau == {final_tau, 8'd0})
    else $error("finished ramp not on target");

  assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  assert property (@(posedge clk) disable iff (rst)
    cmd.op == oplp_pkg::OP_OUT |-> status.out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire

[hw/rtl/oplp_ctrl.sv]
`default_nettype none

module oplp_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [1:0]          s_tuser,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  oplp_pkg::status_t   status,
  output oplp_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_XC0,
    ST_YC1,
    ST_Y,
    ST_OUT,
    ST_TICK,
    ST_TGT,
    ST_TGT_WAIT,
    ST_STEP,
    ST_DEN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SPLIT,
    ST_L2,
    ST_L3,
    ST_L4,
    ST_FRAC,
    ST_POLY,
    ST_TP,
    ST_COEF
  } state_t;

  state_t state;

  always_comb begin
    s_tready = (state == ST_IDLE) && !cfg_we;
    cmd.load = 1'b0;
    cmd.op   = oplp_pkg::OP_NONE;
    unique case (state)
      ST_IDLE:   cmd.load = s_tvalid && s_tready;
      ST_XC0:    cmd.op = oplp_pkg::OP_MUL_XC0;
      ST_YC1:    cmd.op = oplp_pkg::OP_MUL_YC1;
      ST_Y:      cmd.op = oplp_pkg::OP_Y;
      ST_OUT:    if (status.out_free) cmd.op = oplp_pkg::OP_OUT;
      ST_TICK:   if (status.ramp_active) cmd.op = oplp_pkg::OP_TICK;
      ST_TGT:    if (!status.tau_same) cmd.op = oplp_pkg::OP_TARGET;
      ST_STEP:   cmd.op = oplp_pkg::OP_STEP;
      ST_DEN:    cmd.op = oplp_pkg::OP_MUL_DEN;
      ST_DIV_GO: cmd.op = status.den_zero ? oplp_pkg::OP_COEF_ZERO : oplp_pkg::OP_DIV_A;
      ST_SPLIT:  cmd.op = status.a_big ? oplp_pkg::OP_COEF_ZERO : oplp_pkg::OP_SPLIT;
      ST_L2:     cmd.op = oplp_pkg::OP_L2;
      ST_L3:     cmd.op = oplp_pkg::OP_L3;
      ST_L4:     cmd.op = oplp_pkg::OP_L4;
      ST_FRAC:   cmd.op = oplp_pkg::OP_FRAC;
      ST_POLY:   cmd.op = oplp_pkg::OP_POLY;
      ST_TP:     cmd.op = oplp_pkg::OP_MUL_TP;
      ST_COEF:   cmd.op = oplp_pkg::OP_COEF;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_we && cfg_index == oplp_pkg::REG_FS) begin
            state <= ST_DEN;
          end else if (s_tvalid && s_tready) begin
            unique case (s_tuser)
              oplp_pkg::KIND_SAMPLE: state <= ST_XC0;
              oplp_pkg::KIND_TICK:   state <= ST_TICK;
              oplp_pkg::KIND_TARGET: state <= ST_TGT;
              default:               state <= ST_IDLE;
            endcase
          end
        end
        ST_XC0: state <= ST_YC1;
        ST_YC1: state <= ST_Y;
        ST_Y:   state <= ST_OUT;
        ST_OUT: if (status.out_free) state <= ST_IDLE;
        ST_TICK: state <= status.ramp_active ? ST_DEN : ST_IDLE;
        ST_TGT:  state <= status.tau_same ? ST_IDLE : ST_TGT_WAIT;
        ST_TGT_WAIT: if (!status.div_busy) state <= ST_STEP;
        ST_STEP: state <= ST_IDLE;
        ST_DEN:  state <= ST_DIV_GO;
        ST_DIV_GO: state <= status.den_zero ? ST_IDLE : ST_DIV_WAIT;
        ST_DIV_WAIT: if (!status.div_busy) state <= ST_SPLIT;
        ST_SPLIT: state <= status.a_big ? ST_IDLE : ST_L2;
        ST_L2:   state <= ST_L3;
        ST_L3:   state <= ST_L4;
        ST_L4:   state <= ST_FRAC;
        ST_FRAC: state <= ST_POLY;
        ST_POLY: state <= ST_TP;
        ST_TP:   state <= ST_COEF;
        ST_COEF: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/one_pole_lowpass_tau_ramp.sv]
// one-pole lowpass with ramped time constant
// input stream: tuser selects the request kind (sample, block tick, new target);
//   tdata carries the sample (Q1.23) and the target time constant (ms, 8 fraction bits)
// output stream: one filtered sample (Q1.23) per sample request, none for others
// config port: index 0 sample rate in Hz, index 1 ramp length in ticks
// sample request: accepted in idle, then XC0, YC1, Y and OUT fill the output register;
//   the next request is taken after OUT, which waits while the register is still full
// block tick during a ramp: steps the time constant, then the bit-serial divider
//   is followed by the table lookup and polynomial steps on the shared multiplier
// target request: when a ramp starts, the divider computes the step size
// a sample rate write in idle recomputes the coefficients (no request taken meanwhile)
// reset: pass-through coefficients, time constant 0, 44100 Hz, ramp length 1
// a stalled receiver holds the result; the block takes new requests meanwhile and
//   waits only when a second sample result is ready and the register is still full
`default_nettype none

module one_pole_lowpass_tau_ramp (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [55:0] s_tdata,   // sample_in[23:0], target_time_ms[48:24], zero pad
  input  wire  [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // sample_out[23:0]
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [17:0] cfg_data
);

  oplp_pkg::cmd_t    cmd;
  oplp_pkg::status_t status;

  oplp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .status    (status),
    .cmd       (cmd)
  );

  oplp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

[verif/tb_one_pole_lowpass_tau_ramp.sv]
`default_nettype none

module tb_one_pole_lowpass_tau_ramp;

  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  kind;
    logic [23:0] smp;
    logic [24:0] tgt;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [17:0] cfg_data = '0;

  one_pole_lowpass_tau_ramp dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // filter model state
  logic [31:0] exp_rom [oplp_pkg::COEFF_DEPTH];
  logic [17:0] fs_hz;
  logic [15:0] ramp_len;
  int          y_state;
  logic [23:0] c1;
  logic [24:0] c0;
  logic [31:0] tau_now;
  logic [23:0] tau_final;
  int          tau_inc;
  logic [15:0] ramp_left;

  req_t        pending_reqs [$];
  logic [23:0] want_samples [$];
  req_t        on_bus;
  bit          fired = 0;
  int          burst_left = 4, gap_left = 0;
  int          hold_left = 0;
  bit          start_hold = 0;
  int          rx_mode = 0;
  int          errors = 0;
  int          n_samples = 0, n_ticks = 0, n_targets = 0, n_cfg = 0;
  longint      cycles = 0;

  function automatic void recompute_coeffs();
    longint unsigned den, a, hi, lo, l, l2, l3, l4, p, v;
    den = longint'(fs_hz) * longint'(tau_now);
    v = 0;
    if (den != 0) begin
      a = (64'd1000 << 40) / den;
      hi = a >> oplp_pkg::FINE_BITS;
      if (hi < oplp_pkg::COEFF_DEPTH) begin
        lo = a - (hi << oplp_pkg::FINE_BITS);
        l = lo << 7;
        l2 = (l * l) >> 31;
        l3 = (l2 * l) >> 31;
        l4 = (l3 * l) >> 31;
        p = 64'h8000_0000 - l + (l2 >> 1) - l3 / 6 + l4 / 24;
        v = (longint'(exp_rom[hi]) * p + (64'd1 << 30)) >> 31;
        v = (v + 64) >> 7;
        if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
      end
    end
    c1 = v[23:0];
    c0 = 25'h100_0000 - {1'b0, c1};
  endfunction

  function automatic void reset_filter();
    fs_hz = oplp_pkg::FS_RESET;
    ramp_len = 16'd1;
    y_state = 0;
    tau_now = 0;
    tau_final = 0;
    tau_inc = 0;
    ramp_left = 16'd1;
    recompute_coeffs();
  endfunction

  function automatic void apply_request(req_t r);
    longint x, acc, y, o, t, tgt, ticks, nt;
    case (r.kind)
      oplp_pkg::KIND_SAMPLE: begin
        x = longint'($signed(r.smp));
        acc = x * longint'(c0) * 256 + longint'(y_state) * longint'(c1);
        y = (acc + (64'sd1 << 23)) >>> 24;
        if (y > 64'sd2147483647) y = 64'sd2147483647;
        if (y < -64'sd2147483648) y = -64'sd2147483648;
        o = (y + 128) >>> 8;
        if (o > 64'sd8388607) o = 64'sd8388607;
        if (o < -64'sd8388608) o = -64'sd8388608;
        y_state = int'(y);
        want_samples.push_back(o[23:0]);
        n_samples++;
      end
      oplp_pkg::KIND_TICK: begin
        n_ticks++;
        if (ramp_left != 0) begin
          if (ramp_left == 1) begin
            tau_now = {tau_final, 8'd0};
            ramp_left = 0;
          end else begin
            ramp_left--;
            nt = longint'(tau_now) + longint'(tau_inc);
            if (nt < 0) nt = 0;
            if (nt > 64'sd4294967295) nt = 64'sd4294967295;
            tau_now = nt[31:0];
          end
          recompute_coeffs();
        end
      end
      oplp_pkg::KIND_TARGET: begin
        n_targets++;
        t = longint'($signed(r.tgt));
        if (t < 0) t = 0;
        tgt = t * 256;
        if (tgt != longint'(tau_now)) begin
          ticks = (ramp_len != 0) ? longint'(ramp_len) : 1;
          tau_final = t[23:0];
          ramp_left = ticks[15:0];
          nt = (tgt - longint'(tau_now)) / ticks;
          if (nt > 64'sd2147483647) nt = 64'sd2147483647;
          if (nt < -64'sd2147483648) nt = -64'sd2147483648;
          tau_inc = int'(nt);
        end
      end
      default: ;
    endcase
  endfunction

  // input side: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || fired) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        on_bus = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= on_bus.kind;
        s_tdata <= {7'd0, on_bus.tgt, on_bus.smp};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side: stall pattern plus long hold-off
  always @(negedge clk) begin
    if (start_hold) begin
      start_hold = 0;
      hold_left = 600;
    end
    if (cycles % 128 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_mode == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    logic [23:0] want;
    cycles++;
    fired = s_tvalid && s_tready;
    if (!rst && fired) apply_request(on_bus);
    if (!rst && m_tvalid && m_tready) begin
      if (want_samples.size() == 0) begin
        $display("%0t: unexpected sample_out, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = want_samples.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: sample_out mismatch, expected %h, actual %h", $time, want, m_tdata);
          errors++;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("tb_one_pole_lowpass_tau_ramp: FAIL");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] kind, logic [23:0] smp, logic [24:0] tgt);
    req_t r;
    r.kind = kind;
    r.smp = smp;
    r.tgt = tgt;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_tvalid || want_samples.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [17:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == oplp_pkg::REG_FS) begin
      fs_hz = val;
      recompute_coeffs();
    end else begin
      ramp_len = val[15:0];
    end
    n_cfg++;
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [24:0] pick_target();
    case ($urandom_range(0, 9))
      0: return 25'd0;
      1: return 25'($urandom_range(1, 16)) | 25'h100_0000;
      2: return 25'($urandom);
      3: return 25'($urandom_range(1, 64));
      default: return 25'($urandom_range(1, 5120));
    endcase
  endfunction

  task automatic random_traffic(int count);
    int made, n;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(2'($urandom_range(0, 3)), 24'($urandom), 25'($urandom));
        made++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          push_req(oplp_pkg::KIND_TARGET, 24'($urandom), pick_target());
          made++;
        end
        n = $urandom_range(1, 12);
        repeat (n) push_req(oplp_pkg::KIND_SAMPLE, 24'($urandom), 25'($urandom));
        push_req(oplp_pkg::KIND_TICK, 24'($urandom), 25'($urandom));
        made += n + 1;
      end
    end
  endtask

  initial begin
    logic [17:0] fs_set [6];
    logic [17:0] ramp_set [6];
    fs_set = '{18'd44100, 18'd192000, 18'd1000, 18'h3FFFF, 18'd0, 18'd48000};
    ramp_set = '{18'd1, 18'd8, 18'd0, 18'd65535, 18'd3, 18'd2};
    for (int k = 0; k < oplp_pkg::COEFF_DEPTH; k++) begin
      longint unsigned r;
      r = 64'h8000_0000;
      for (int j = 0; j < 28; j++) begin
        if (((k << oplp_pkg::FINE_BITS) >> j) & 1) begin
          r = (r * oplp_pkg::EXP_POW2[j] + (64'd1 << 30)) >> 31;
        end
      end
      exp_rom[k] = r[31:0];
    end
    reset_filter();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (200) @(posedge clk);

    // passthrough, idle tick, clamped and repeated targets, ignored kind
    push_req(oplp_pkg::KIND_SAMPLE, 24'h7F_FFFF, 25'h1FF_FFFF);
    push_req(oplp_pkg::KIND_SAMPLE, 24'h80_0000, 25'h0);
    push_req(oplp_pkg::KIND_SAMPLE, 24'h00_0001, 25'h0);
    push_req(oplp_pkg::KIND_SAMPLE, 24'hFF_FFFF, 25'h0);
    push_req(2'd3, 24'hFF_FFFF, 25'h1FF_FFFF);
    push_req(oplp_pkg::KIND_TICK, 24'h0, 25'h0);
    push_req(oplp_pkg::KIND_TICK, 24'h0, 25'h0);
    push_req(oplp_pkg::KIND_TARGET, 24'h0, 25'h1FF_FFFB);
    push_req(oplp_pkg::KIND_TARGET, 24'h0, 25'd768);
    push_req(oplp_pkg::KIND_TICK, 24'h0, 25'h0);
    push_req(oplp_pkg::KIND_SAMPLE, 24'h7F_FFFF, 25'h0);
    push_req(oplp_pkg::KIND_SAMPLE, 24'h7F_FFFF, 25'h0);
    push_req(oplp_pkg::KIND_SAMPLE, 24'h80_0000, 25'h0);
    push_req(oplp_pkg::KIND_TARGET, 24'h0, 25'd768);
    push_req(oplp_pkg::KIND_TARGET, 24'h0, 25'h0FF_FFFF);
    push_req(oplp_pkg::KIND_TICK, 24'h0, 25'h0);
    push_req(oplp_pkg::KIND_SAMPLE, 24'h40_0000, 25'h0);
    push_req(oplp_pkg::KIND_TARGET, 24'h0, 25'd1);
    push_req(oplp_pkg::KIND_TICK, 24'h0, 25'h0);
    push_req(oplp_pkg::KIND_SAMPLE, 24'h80_0000, 25'h0);
    push_req(oplp_pkg::KIND_TARGET, 24'h0, 25'h0);
    push_req(oplp_pkg::KIND_TICK, 24'h0, 25'h0);
    push_req(oplp_pkg::KIND_SAMPLE, 24'h12_3456, 25'h0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(oplp_pkg::REG_FS, fs_set[ph]);
      write_reg(oplp_pkg::REG_TICKS, ramp_set[ph]);
      random_traffic(255);
      if (ph == 1) begin
        repeat (20) @(posedge clk);
        start_hold = 1;
      end
      drain();
    end

    $display("covered %0d samples, %0d ticks, %0d targets, %0d register writes",
             n_samples, n_ticks, n_targets, n_cfg);
    $display("six rate/ramp settings incl. zero and full scale, one long output hold-off");
    if (errors == 0) begin
      $display("tb_one_pole_lowpass_tau_ramp: PASS");
    end else begin
      $display("tb_one_pole_lowpass_tau_ramp: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/oplp_pkg.sv
hw/rtl/oplp_div.sv
hw/rtl/oplp_dp.sv
hw/rtl/oplp_ctrl.sv
hw/rtl/one_pole_lowpass_tau_ramp.sv
verif/tb_one_pole_lowpass_tau_ramp.sv
